// ===== design/ated_pkg.sv =====
package ated_pkg;

  // Screen geometry. The cursor ports are 7 and 5 bits wide, which covers
  // up to 128 columns and 32 rows.
  localparam int COLS  = 80;
  localparam int ROWS  = 24;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  // Depth of the queue between the classifier and the executor
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Result operation codes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_CLEOL  = 3'd2;
  localparam logic [2:0] OP_CLS    = 3'd3;
  localparam logic [2:0] OP_SCROLL = 3'd4;

  // Byte values of interest
  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_LBRK  = 8'd91;
  localparam logic [7:0] BYTE_SEMI  = 8'd59;
  localparam logic [7:0] BYTE_ZERO  = 8'd48;
  localparam logic [7:0] BYTE_NINE  = 8'd57;
  localparam logic [7:0] BYTE_K     = 8'd75;
  localparam logic [7:0] BYTE_C     = 8'd67;
  localparam logic [7:0] BYTE_H     = 8'd72;
  localparam logic [7:0] BYTE_J     = 8'd74;

  // Byte class, independent of the parser phase
  typedef enum logic [3:0] {
    CL_BS,
    CL_TAB,
    CL_CR,
    CL_NL,
    CL_ESC,
    CL_LBRK,
    CL_DIGIT,
    CL_SEMI,
    CL_FIN_K,
    CL_FIN_C,
    CL_FIN_H,
    CL_FIN_J,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] code;
  } item_t;

endpackage

// ===== design/ansi_terminal_escape_decoder.sv =====
// Byte-stream terminal decoder: takes one received byte per input beat and
// returns exactly one result beat for it, carrying the screen operation
// (none, write cell, clear to line end, clear screen, scroll up), the cell
// position and character where they apply, and the cursor after the byte.
// Control bytes, ESC sequences and CSI sequences (K, C, H, J; others are
// consumed silently) are handled as a VT100-style parser with the cursor
// clamped to the screen and numeric parameters saturating at 255. One byte
// is taken every cycle when the output side keeps up; a result passes the
// classifier register, a queue slot and the executor output register, in that
// order, before it is presented. The executor updates the cursor and parser
// state for each byte it takes, which sets the one-byte-per-cycle rate.
module ansi_terminal_escape_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   op,
  output logic [ated_pkg::COL_W-1:0]   cell_col,
  output logic [ated_pkg::ROW_W-1:0]   cell_row,
  output logic [7:0]                   char_code,
  output logic [ated_pkg::COL_W-1:0]   cursor_col,
  output logic [ated_pkg::ROW_W-1:0]   cursor_row
);

  // Classified beats from the front end into the queue
  logic             fr_valid;
  logic             fr_ready;
  ated_pkg::item_t  fr_item;

  // Queue into the executor
  logic             q_valid;
  logic             q_ready;
  ated_pkg::item_t  q_item;

  // Front end: classify each byte without regard to parser phase
  ated_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  // Short two-entry queue: lets the executor stall on the output without blocking input until it fills
  ated_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Back end: advance parser and cursor, hold the result until taken
  ated_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .op         (op),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .char_code  (char_code),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

endmodule

// ===== design/ated_front.sv =====
module ated_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               item_valid,
  input  logic               item_ready,
  output ated_pkg::item_t    item
);

  ated_pkg::cls_t cls_next;

  always_comb begin
    case (rx_byte)
      ated_pkg::BYTE_BS:   cls_next = ated_pkg::CL_BS;
      ated_pkg::BYTE_TAB:  cls_next = ated_pkg::CL_TAB;
      ated_pkg::BYTE_CR:   cls_next = ated_pkg::CL_CR;
      ated_pkg::BYTE_LF:   cls_next = ated_pkg::CL_NL;
      ated_pkg::BYTE_NUL:  cls_next = ated_pkg::CL_NL;
      ated_pkg::BYTE_ESC:  cls_next = ated_pkg::CL_ESC;
      ated_pkg::BYTE_LBRK: cls_next = ated_pkg::CL_LBRK;
      ated_pkg::BYTE_SEMI: cls_next = ated_pkg::CL_SEMI;
      ated_pkg::BYTE_K:    cls_next = ated_pkg::CL_FIN_K;
      ated_pkg::BYTE_C:    cls_next = ated_pkg::CL_FIN_C;
      ated_pkg::BYTE_H:    cls_next = ated_pkg::CL_FIN_H;
      ated_pkg::BYTE_J:    cls_next = ated_pkg::CL_FIN_J;
      default: begin
        if (rx_byte inside {[ated_pkg::BYTE_ZERO:ated_pkg::BYTE_NINE]}) begin
          cls_next = ated_pkg::CL_DIGIT;
        end else begin
          cls_next = ated_pkg::CL_OTHER;
        end
      end
    endcase
  end

  // Hold the classified beat until the queue takes it
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cls  <= cls_next;
      item.code <= rx_byte;
    end
  end

endmodule

// ===== design/ated_queue.sv =====
module ated_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  ated_pkg::item_t    wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output ated_pkg::item_t    rd_item
);

  ated_pkg::item_t                    slots [ated_pkg::QDEPTH];
  logic [ated_pkg::QPTR_W-1:0]        wr_ptr;
  logic [ated_pkg::QPTR_W-1:0]        rd_ptr;
  logic [ated_pkg::QCNT_W-1:0]        count;
  logic                               push;
  logic                               pop;

  assign wr_ready = count != ated_pkg::QCNT_W'(ated_pkg::QDEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ated_pkg::QPTR_W'(ated_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ated_pkg::QPTR_W'(ated_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= ated_pkg::QCNT_W'(ated_pkg::QDEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

// ===== design/ated_back.sv =====
module ated_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  ated_pkg::item_t              item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   op,
  output logic [ated_pkg::COL_W-1:0]   cell_col,
  output logic [ated_pkg::ROW_W-1:0]   cell_row,
  output logic [7:0]                   char_code,
  output logic [ated_pkg::COL_W-1:0]   cursor_col,
  output logic [ated_pkg::ROW_W-1:0]   cursor_row
);

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI,
    PH_SKIP
  } phase_t;

  localparam logic [ated_pkg::COL_W-1:0] COL_MAX = ated_pkg::COL_W'(ated_pkg::COLS - 1);
  localparam logic [ated_pkg::ROW_W-1:0] ROW_MAX = ated_pkg::ROW_W'(ated_pkg::ROWS - 1);

  phase_t                       phase, phase_next;
  logic [7:0]                   first_param, first_param_next;
  logic [7:0]                   second_param, second_param_next;
  logic                         param_slot, param_slot_next;
  logic [ated_pkg::COL_W-1:0]   col_pos, col_pos_next;
  logic [ated_pkg::ROW_W-1:0]   row_pos, row_pos_next;
  logic [2:0]                   op_next;
  logic [ated_pkg::COL_W-1:0]   cell_col_next;
  logic [ated_pkg::ROW_W-1:0]   cell_row_next;
  logic [7:0]                   char_code_next;

  logic                         take;
  logic [7:0]                   cur_param;
  logic [11:0]                  acc;
  logic [7:0]                   acc_sat;
  logic [8:0]                   col_fwd;
  logic [ated_pkg::COL_W-1:0]   col_inc;
  logic [7:0]                   first_m1;
  logic [7:0]                   second_m1;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  // Decimal accumulate with saturation
  assign cur_param = param_slot ? second_param : first_param;
  assign acc       = {1'b0, cur_param, 3'b000} + {3'b000, cur_param, 1'b0}
                   + {8'd0, item.code[3:0]};
  assign acc_sat   = (acc > 12'd255) ? 8'd255 : acc[7:0];

  assign col_fwd   = {2'b00, col_pos} + {1'b0, first_param};
  assign col_inc   = (col_pos >= COL_MAX) ? COL_MAX : col_pos + 1'b1;
  assign first_m1  = first_param - 8'd1;
  assign second_m1 = second_param - 8'd1;

  always_comb begin
    phase_next        = phase;
    first_param_next  = first_param;
    second_param_next = second_param;
    param_slot_next   = param_slot;
    col_pos_next      = col_pos;
    row_pos_next      = row_pos;
    op_next           = ated_pkg::OP_NONE;
    cell_col_next     = '0;
    cell_row_next     = '0;
    char_code_next    = '0;
    case (phase)
      PH_ESC: begin
        if (item.cls == ated_pkg::CL_LBRK) begin
          phase_next        = PH_CSI;
          first_param_next  = '0;
          second_param_next = '0;
          param_slot_next   = 1'b0;
        end else begin
          phase_next = PH_TEXT;
        end
      end
      PH_CSI, PH_SKIP: begin
        if (item.cls == ated_pkg::CL_DIGIT) begin
          if (phase == PH_CSI) begin
            if (param_slot) begin
              second_param_next = acc_sat;
            end else begin
              first_param_next = acc_sat;
            end
          end
        end else if (item.cls == ated_pkg::CL_SEMI) begin
          if (phase == PH_CSI) begin
            if (param_slot) begin
              phase_next = PH_SKIP;
            end else begin
              param_slot_next = 1'b1;
            end
          end
        end else begin
          phase_next = PH_TEXT;
          case (item.cls)
            ated_pkg::CL_FIN_K: begin
              op_next       = ated_pkg::OP_CLEOL;
              cell_col_next = col_pos;
              cell_row_next = row_pos;
            end
            ated_pkg::CL_FIN_C: begin
              col_pos_next = (col_fwd > {2'b00, COL_MAX}) ? COL_MAX
                                                          : col_fwd[ated_pkg::COL_W-1:0];
            end
            ated_pkg::CL_FIN_H: begin
              if (first_param != 8'd0 && second_param != 8'd0) begin
                row_pos_next = (first_m1 > 8'(ated_pkg::ROWS - 1)) ? ROW_MAX
                                                                   : first_m1[ated_pkg::ROW_W-1:0];
                col_pos_next = (second_m1 > 8'(ated_pkg::COLS - 1)) ? COL_MAX
                                                                    : second_m1[ated_pkg::COL_W-1:0];
              end
            end
            ated_pkg::CL_FIN_J: begin
              op_next      = ated_pkg::OP_CLS;
              col_pos_next = '0;
              row_pos_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        case (item.cls)
          ated_pkg::CL_BS: begin
            if (col_pos != '0) begin
              col_pos_next = col_pos - 1'b1;
            end
          end
          ated_pkg::CL_TAB: col_pos_next = col_inc;
          ated_pkg::CL_CR:  col_pos_next = '0;
          ated_pkg::CL_NL: begin
            if (row_pos >= ROW_MAX) begin
              row_pos_next = ROW_MAX;
              op_next      = ated_pkg::OP_SCROLL;
            end else begin
              row_pos_next = row_pos + 1'b1;
            end
          end
          ated_pkg::CL_ESC: phase_next = PH_ESC;
          default: begin
            op_next        = ated_pkg::OP_WRITE;
            cell_col_next  = col_pos;
            cell_row_next  = row_pos;
            char_code_next = item.code;
            col_pos_next   = col_inc;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TEXT;
      first_param  <= '0;
      second_param <= '0;
      param_slot   <= 1'b0;
      col_pos      <= '0;
      row_pos      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        first_param  <= first_param_next;
        second_param <= second_param_next;
        param_slot   <= param_slot_next;
        col_pos      <= col_pos_next;
        row_pos      <= row_pos_next;
        op           <= op_next;
        cell_col     <= cell_col_next;
        cell_row     <= cell_row_next;
        char_code    <= char_code_next;
        cursor_col   <= col_pos_next;
        cursor_row   <= row_pos_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    col_pos <= COL_MAX && row_pos <= ROW_MAX)
    else $error("cursor outside the screen");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && op != ated_pkg::OP_WRITE |-> char_code == 8'd0)
    else $error("char_code set without a cell write");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && op == ated_pkg::OP_SCROLL |-> cursor_row == ROW_MAX)
    else $error("scroll away from the last row");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && op == ated_pkg::OP_CLS |-> cursor_col == '0 && cursor_row == '0)
    else $error("screen clear without homing the cursor");

  assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && cursor_col == col_pos && cursor_row == row_pos)
    else $error("result cursor differs from held cursor");

endmodule
